[sv/pcs_pkg.sv]
// Shared types and constants for the PUCT child select block.
// Used by pcs_iter_unit and puct_child_select_unit; no dependencies.
package pcs_pkg;

   localparam int ACTION_BITS = 15;
   localparam int FRAC_BITS   = 16;

   localparam int VISIT_BITS  = 24;
   localparam int SUM_BITS    = 40;
   localparam int PRIOR_BITS  = 17;
   localparam int VL_BITS     = 10;
   localparam int WEIGHT_BITS = 24;
   localparam int FPU_BITS    = 20;
   localparam int SCORE_BITS  = 48;

   // sqrt of (visits + vl + 1) scaled by 4^F
   localparam int RAD_IN_BITS = 26;
   localparam int RAD_BITS    = RAD_IN_BITS + 2 * FRAC_BITS;
   localparam int ROOT_BITS   = 13 + FRAC_BITS;
   localparam int WP_BITS     = WEIGHT_BITS + PRIOR_BITS - FRAC_BITS;
   localparam int PROD_BITS   = WP_BITS + ROOT_BITS;
   localparam int DEN_BITS    = VISIT_BITS + 1;
   localparam int MEAN_BITS   = SUM_BITS + 1;
   localparam int ACC_BITS    = SCORE_BITS + 8;
   localparam int OPND_BITS   = (RAD_BITS > PROD_BITS) ? RAD_BITS : PROD_BITS;
   localparam int REM_BITS    = ROOT_BITS + 2;
   localparam int CNT_BITS    = $clog2(OPND_BITS + 1);

   localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
   localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

   typedef struct packed {
      logic [ACTION_BITS-1:0]       action_index;
      logic [VISIT_BITS-1:0]        child_visits;
      logic signed [SUM_BITS-1:0]   child_value_sum;
      logic [PRIOR_BITS-1:0]        child_prior;
      logic [VL_BITS-1:0]           child_virtual_loss;
      logic [VISIT_BITS-1:0]        parent_visits;
      logic signed [SUM_BITS-1:0]   parent_value_sum;
      logic [VL_BITS-1:0]           parent_virtual_loss;
      logic [WEIGHT_BITS-1:0]       c_puct;
      logic                         last_child;
   } req_type;

   typedef struct packed {
      logic [ACTION_BITS-1:0]       win_action;
      logic signed [SCORE_BITS-1:0] best_score;
   } rsp_type;

   typedef enum logic {
      ITER_DIV,
      ITER_SQRT
   } iter_mode_type;

   typedef struct packed {
      logic          start;
      iter_mode_type mode;
   } iter_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_PMEAN_GO,
      ST_PMEAN_WAIT,
      ST_CMEAN_GO,
      ST_CMEAN_WAIT,
      ST_MUL_WP,
      ST_MUL_PR,
      ST_EXPL_GO,
      ST_EXPL_WAIT,
      ST_SCORE
   } state_type;

endpackage

[sv/pcs_iter_unit.sv]
// Shared radix-2 restoring unit: unsigned divide or integer square root.
// One quotient / root bit per cycle. Depends on pcs_pkg.
module pcs_iter_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  pcs_pkg::iter_cmd_type         cmd,
   input  logic [pcs_pkg::PROD_BITS-1:0] div_num,
   input  logic [pcs_pkg::DEN_BITS-1:0]  div_den,
   input  logic [pcs_pkg::RAD_IN_BITS-1:0] rad_in,
   output logic                          done,
   output logic [pcs_pkg::PROD_BITS-1:0] result
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   pcs_pkg::iter_mode_type          mode_ff, mode_in;
   logic [pcs_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [pcs_pkg::OPND_BITS-1:0]   opnd_ff, opnd_in;
   logic [pcs_pkg::DEN_BITS-1:0]    den_ff, den_in;
   logic [pcs_pkg::REM_BITS-1:0]    rem_ff, rem_in;
   logic [pcs_pkg::PROD_BITS-1:0]   quo_ff, quo_in;

   logic [pcs_pkg::REM_BITS:0]      rem_sh;
   logic [pcs_pkg::REM_BITS:0]      trial;
   logic [pcs_pkg::REM_BITS:0]      diff;
   logic                            ge;

   always_comb begin
      if (mode_ff == pcs_pkg::ITER_SQRT) begin
         rem_sh = {rem_ff[pcs_pkg::REM_BITS-2:0], opnd_ff[pcs_pkg::OPND_BITS-1 -: 2]};
         trial  = (pcs_pkg::REM_BITS+1)'({quo_ff[pcs_pkg::ROOT_BITS-1:0], 2'b01});
      end else begin
         rem_sh = {rem_ff, opnd_ff[pcs_pkg::OPND_BITS-1]};
         trial  = (pcs_pkg::REM_BITS+1)'(den_ff);
      end
      ge   = (rem_sh >= trial);
      diff = rem_sh - trial;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      opnd_in = opnd_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         mode_in = cmd.mode;
         den_in  = div_den;
         rem_in  = '0;
         quo_in  = '0;
         if (cmd.mode == pcs_pkg::ITER_SQRT) begin
            // left-aligned radicand; only the top ROOT_BITS digit pairs are used
            opnd_in = pcs_pkg::OPND_BITS'(rad_in)
                      << (pcs_pkg::OPND_BITS - pcs_pkg::RAD_IN_BITS);
            cnt_in  = pcs_pkg::CNT_BITS'(pcs_pkg::ROOT_BITS);
         end else begin
            opnd_in = pcs_pkg::OPND_BITS'(div_num)
                      << (pcs_pkg::OPND_BITS - pcs_pkg::PROD_BITS);
            cnt_in  = pcs_pkg::CNT_BITS'(pcs_pkg::PROD_BITS);
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[pcs_pkg::REM_BITS-1:0] : rem_sh[pcs_pkg::REM_BITS-1:0];
         quo_in = {quo_ff[pcs_pkg::PROD_BITS-2:0], ge};
         opnd_in = (mode_ff == pcs_pkg::ITER_SQRT) ? (opnd_ff << 2) : (opnd_ff << 1);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == pcs_pkg::CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         mode_ff <= pcs_pkg::ITER_DIV;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
      end
      opnd_ff <= opnd_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign done   = done_ff;
   assign result = quo_ff;

endmodule

[sv/puct_child_select_unit.sv]
// PUCT child selection top level: sequencer, datapath and result register.
// Depends on pcs_pkg and pcs_iter_unit.
//
// Children of one node arrive one transfer at a time; the block stalls its input
// while a child is scored. Every child is scored by one shared bit-per-cycle
// divide/square-root unit. The first child of a group runs the parent root, the
// parent mean, the child mean, two multiplies, the exploration divide and the
// score state, each divide with a start state and a wait state; later children
// start at the child mean. A child whose visits plus virtual loss are zero skips
// its mean divide, and a parent whose visits plus virtual loss are zero skips
// the parent mean divide. The best action leaves through an output register on
// the last child, so the next group may start while it waits; a last child whose
// result finds that register still stalled waits in the score state until it
// frees.
module puct_child_select_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  pcs_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output pcs_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wr_en,
   input  logic [pcs_pkg::FPU_BITS-1:0]     csr_wr_data
);

   pcs_pkg::state_type state_ff, state_in;

   logic [pcs_pkg::FPU_BITS-1:0]            fpu_ff;
   logic                                    in_group_ff;
   logic signed [pcs_pkg::SCORE_BITS-1:0]   parent_mean_ff;
   logic [pcs_pkg::ROOT_BITS-1:0]           parent_root_ff;
   logic [pcs_pkg::WEIGHT_BITS-1:0]         weight_ff;
   logic signed [pcs_pkg::SCORE_BITS-1:0]   best_score_ff;
   logic [pcs_pkg::ACTION_BITS-1:0]         run_action_ff;
   logic                                    have_best_ff;
   logic                                    rsp_valid_ff;
   pcs_pkg::rsp_type                        rsp_data_ff;

   pcs_pkg::req_type                        item_ff;
   logic                                    neg_ff;
   logic signed [pcs_pkg::SCORE_BITS-1:0]   exploit_ff;
   logic [pcs_pkg::WP_BITS-1:0]             wp_ff;
   logic [pcs_pkg::PROD_BITS-1:0]           prod_ff;
   logic signed [pcs_pkg::SCORE_BITS-1:0]   score_ff;

   pcs_pkg::iter_cmd_type                   cmd;
   logic [pcs_pkg::PROD_BITS-1:0]           div_num;
   logic [pcs_pkg::DEN_BITS-1:0]            div_den;
   logic [pcs_pkg::RAD_IN_BITS-1:0]         rad_in;
   logic                                    iter_done;
   logic [pcs_pkg::PROD_BITS-1:0]           iter_result;

   logic                                    accept;
   logic                                    rsp_busy;
   logic                                    rsp_load;
   logic [pcs_pkg::DEN_BITS-1:0]            pden, cden;
   logic signed [pcs_pkg::MEAN_BITS-1:0]    padj, cadj;
   logic [pcs_pkg::MEAN_BITS-1:0]           pmag, cmag;
   logic signed [pcs_pkg::SCORE_BITS-1:0]   qmean;
   logic signed [pcs_pkg::SCORE_BITS-1:0]   fpu_ext;
   logic signed [pcs_pkg::ACC_BITS-1:0]     acc;
   logic signed [pcs_pkg::SCORE_BITS-1:0]   sat_score;
   logic                                    take;
   logic signed [pcs_pkg::SCORE_BITS-1:0]   sel_score;
   logic [pcs_pkg::ACTION_BITS-1:0]         sel_action;

   pcs_iter_unit u_iter (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .div_num (div_num),
      .div_den (div_den),
      .rad_in  (rad_in),
      .done    (iter_done),
      .result  (iter_result)
   );

   assign accept   = req_valid && !req_stall;
   assign rsp_busy = rsp_valid_ff && rsp_stall;
   assign rsp_load = (state_ff == pcs_pkg::ST_SCORE) && item_ff.last_child && !rsp_busy;

   // operand prep: mean numerator is sum + vl * 2^F, divided in magnitude
   always_comb begin
      pden = pcs_pkg::DEN_BITS'(item_ff.parent_visits)
             + pcs_pkg::DEN_BITS'(item_ff.parent_virtual_loss);
      cden = pcs_pkg::DEN_BITS'(item_ff.child_visits)
             + pcs_pkg::DEN_BITS'(item_ff.child_virtual_loss);
      padj = pcs_pkg::MEAN_BITS'(item_ff.parent_value_sum)
             + pcs_pkg::MEAN_BITS'({item_ff.parent_virtual_loss,
                                    {pcs_pkg::FRAC_BITS{1'b0}}});
      cadj = pcs_pkg::MEAN_BITS'(item_ff.child_value_sum)
             + pcs_pkg::MEAN_BITS'({item_ff.child_virtual_loss,
                                    {pcs_pkg::FRAC_BITS{1'b0}}});
      pmag = padj[pcs_pkg::MEAN_BITS-1] ? pcs_pkg::MEAN_BITS'(-padj)
                                        : pcs_pkg::MEAN_BITS'(padj);
      cmag = cadj[pcs_pkg::MEAN_BITS-1] ? pcs_pkg::MEAN_BITS'(-cadj)
                                        : pcs_pkg::MEAN_BITS'(cadj);
      rad_in = pcs_pkg::RAD_IN_BITS'(pden) + pcs_pkg::RAD_IN_BITS'(1);
      fpu_ext = $signed({{(pcs_pkg::SCORE_BITS-pcs_pkg::FPU_BITS){1'b0}}, fpu_ff});
      qmean = $signed(pcs_pkg::SCORE_BITS'(iter_result[pcs_pkg::MEAN_BITS-1:0]));
   end

   // score = exploit + explore, clamped to the score range
   always_comb begin
      acc = pcs_pkg::ACC_BITS'(exploit_ff)
            + $signed(pcs_pkg::ACC_BITS'(iter_result >> pcs_pkg::FRAC_BITS));
      if (acc > pcs_pkg::ACC_BITS'(pcs_pkg::SCORE_MAX))
         sat_score = pcs_pkg::SCORE_MAX;
      else if (acc < pcs_pkg::ACC_BITS'(pcs_pkg::SCORE_MIN))
         sat_score = pcs_pkg::SCORE_MIN;
      else
         sat_score = acc[pcs_pkg::SCORE_BITS-1:0];
   end

   // first strict maximum wins; first child of a group always taken
   always_comb begin
      take       = !have_best_ff || (score_ff > best_score_ff);
      sel_score  = take ? score_ff : best_score_ff;
      sel_action = take ? item_ff.action_index : run_action_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcs_pkg::ST_IDLE: begin
            if (req_valid)
               state_in = in_group_ff ? pcs_pkg::ST_CMEAN_GO : pcs_pkg::ST_ROOT_GO;
         end
         pcs_pkg::ST_ROOT_GO:   state_in = pcs_pkg::ST_ROOT_WAIT;
         pcs_pkg::ST_ROOT_WAIT: begin
            if (iter_done)
               state_in = pcs_pkg::ST_PMEAN_GO;
         end
         pcs_pkg::ST_PMEAN_GO: begin
            state_in = (pden == '0) ? pcs_pkg::ST_CMEAN_GO : pcs_pkg::ST_PMEAN_WAIT;
         end
         pcs_pkg::ST_PMEAN_WAIT: begin
            if (iter_done)
               state_in = pcs_pkg::ST_CMEAN_GO;
         end
         pcs_pkg::ST_CMEAN_GO: begin
            state_in = (cden == '0) ? pcs_pkg::ST_MUL_WP : pcs_pkg::ST_CMEAN_WAIT;
         end
         pcs_pkg::ST_CMEAN_WAIT: begin
            if (iter_done)
               state_in = pcs_pkg::ST_MUL_WP;
         end
         pcs_pkg::ST_MUL_WP:    state_in = pcs_pkg::ST_MUL_PR;
         pcs_pkg::ST_MUL_PR:    state_in = pcs_pkg::ST_EXPL_GO;
         pcs_pkg::ST_EXPL_GO:   state_in = pcs_pkg::ST_EXPL_WAIT;
         pcs_pkg::ST_EXPL_WAIT: begin
            if (iter_done)
               state_in = pcs_pkg::ST_SCORE;
         end
         pcs_pkg::ST_SCORE: begin
            if (!(item_ff.last_child && rsp_busy))
               state_in = pcs_pkg::ST_IDLE;
         end
         default:               state_in = pcs_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      cmd.start = 1'b0;
      cmd.mode  = pcs_pkg::ITER_DIV;
      div_num   = pcs_pkg::PROD_BITS'(pmag);
      div_den   = pden;
      case (state_ff)
         pcs_pkg::ST_IDLE:     req_stall = 1'b0;
         pcs_pkg::ST_ROOT_GO: begin
            cmd.start = 1'b1;
            cmd.mode  = pcs_pkg::ITER_SQRT;
         end
         pcs_pkg::ST_PMEAN_GO: cmd.start = (pden != '0);
         pcs_pkg::ST_CMEAN_GO: begin
            cmd.start = (cden != '0);
            div_num   = pcs_pkg::PROD_BITS'(cmag);
            div_den   = cden;
         end
         pcs_pkg::ST_EXPL_GO: begin
            cmd.start = 1'b1;
            div_num   = prod_ff;
            div_den   = cden + pcs_pkg::DEN_BITS'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath and group state
   always_ff @(posedge clock) begin
      if (reset) begin
         fpu_ff         <= '0;
         in_group_ff    <= 1'b0;
         parent_mean_ff <= '0;
         parent_root_ff <= '0;
         weight_ff      <= '0;
         best_score_ff  <= pcs_pkg::SCORE_MIN;
         run_action_ff  <= '0;
         have_best_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en)
            fpu_ff <= csr_wr_data;
         if (rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            pcs_pkg::ST_IDLE: begin
               if (accept && !in_group_ff) begin
                  weight_ff   <= req_data.c_puct;
                  in_group_ff <= 1'b1;
               end
            end
            pcs_pkg::ST_ROOT_WAIT: begin
               if (iter_done)
                  parent_root_ff <= iter_result[pcs_pkg::ROOT_BITS-1:0];
            end
            pcs_pkg::ST_PMEAN_GO: begin
               if (pden == '0)
                  parent_mean_ff <= '0;
            end
            pcs_pkg::ST_PMEAN_WAIT: begin
               if (iter_done)
                  parent_mean_ff <= neg_ff ? -qmean : qmean;
            end
            pcs_pkg::ST_SCORE: begin
               if (!(item_ff.last_child && rsp_busy)) begin
                  if (item_ff.last_child) begin
                     in_group_ff    <= 1'b0;
                     have_best_ff   <= 1'b0;
                     best_score_ff  <= pcs_pkg::SCORE_MIN;
                     run_action_ff  <= '0;
                  end else begin
                     have_best_ff   <= 1'b1;
                     best_score_ff  <= sel_score;
                     run_action_ff  <= sel_action;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept)
         item_ff <= req_data;
      case (state_ff)
         pcs_pkg::ST_PMEAN_GO: neg_ff <= padj[pcs_pkg::MEAN_BITS-1];
         pcs_pkg::ST_CMEAN_GO: begin
            neg_ff <= cadj[pcs_pkg::MEAN_BITS-1];
            if (cden == '0)
               exploit_ff <= parent_mean_ff - fpu_ext;
         end
         pcs_pkg::ST_CMEAN_WAIT: begin
            // exploit is minus the child's mean
            if (iter_done)
               exploit_ff <= neg_ff ? qmean : -qmean;
         end
         pcs_pkg::ST_MUL_WP: begin
            wp_ff <= pcs_pkg::WP_BITS'(
                        ((pcs_pkg::WEIGHT_BITS+pcs_pkg::PRIOR_BITS)'(weight_ff)
                         * (pcs_pkg::WEIGHT_BITS+pcs_pkg::PRIOR_BITS)'(item_ff.child_prior))
                        >> pcs_pkg::FRAC_BITS);
         end
         pcs_pkg::ST_MUL_PR: begin
            prod_ff <= pcs_pkg::PROD_BITS'(wp_ff) * pcs_pkg::PROD_BITS'(parent_root_ff);
         end
         pcs_pkg::ST_EXPL_WAIT: begin
            if (iter_done)
               score_ff <= sat_score;
         end
         pcs_pkg::ST_SCORE: begin
            if (rsp_load) begin
               rsp_data_ff.win_action <= sel_action;
               rsp_data_ff.best_score <= sel_score;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
